/* design/pbl_pkg.sv */
// shared types and codes of the point-box locator
package pbl_pkg;

    // command carried in the input tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status carried in the output tuser
    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_NEAREST = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    // register select bit of paddr (word index)
    localparam logic REG_SECTOR_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    // tag that travels with a table read
    typedef struct packed {
        logic valid;
        logic last;
    } t_scan_tag;

    // per-entry verdict leaving the evaluation pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic present;
        logic contain;
    } t_eval_flags;

endpackage

/* design/pbl_ram.sv */
// generic simple dual-port ram with registered read
module pbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pbl_eval.sv */
// three-stage per-entry evaluation: containment, center offsets, squared distance
module pbl_eval #(
    parameter int CW = 24,
    parameter int AW = 6,
    localparam int DW = 2 * CW + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pbl_pkg::t_scan_tag    i_tag,
    input  logic [AW-1:0]         i_idx,
    input  logic [6*CW:0]         i_word,
    input  logic signed [CW-1:0]  i_px,
    input  logic signed [CW-1:0]  i_py,
    input  logic signed [CW-1:0]  i_pz,
    output pbl_pkg::t_eval_flags  o_flags,
    output logic [AW-1:0]         o_idx,
    output logic [DW-1:0]         o_dist
);
    import pbl_pkg::*;

    logic signed [CW-1:0] w_min_x, w_min_y, w_min_z;
    logic signed [CW-1:0] w_max_x, w_max_y, w_max_z;
    logic signed [CW:0]   w_sum_x, w_sum_y, w_sum_z;
    logic signed [CW-1:0] w_cx, w_cy, w_cz;
    logic                 w_contain;

    t_eval_flags          r_a_flags, r_b_flags, r_c_flags;
    logic [AW-1:0]        r_a_idx, r_b_idx, r_c_idx;
    logic signed [CW:0]   r_dx, r_dy, r_dz;
    logic signed [2*CW+1:0] w_sq_x, w_sq_y, w_sq_z;
    logic [2*CW+1:0]      r_sq_x, r_sq_y, r_sq_z;
    logic [DW-1:0]        r_dist;

    assign w_min_x = i_word[0*CW +: CW];
    assign w_min_y = i_word[1*CW +: CW];
    assign w_min_z = i_word[2*CW +: CW];
    assign w_max_x = i_word[3*CW +: CW];
    assign w_max_y = i_word[4*CW +: CW];
    assign w_max_z = i_word[5*CW +: CW];

    // inclusive bounds on all three axes
    assign w_contain = (i_px >= w_min_x) && (i_px <= w_max_x) &&
                       (i_py >= w_min_y) && (i_py <= w_max_y) &&
                       (i_pz >= w_min_z) && (i_pz <= w_max_z);

    // center is floor of the half sum
    assign w_sum_x = {w_min_x[CW-1], w_min_x} + {w_max_x[CW-1], w_max_x};
    assign w_sum_y = {w_min_y[CW-1], w_min_y} + {w_max_y[CW-1], w_max_y};
    assign w_sum_z = {w_min_z[CW-1], w_min_z} + {w_max_z[CW-1], w_max_z};
    assign w_cx    = w_sum_x[CW:1];
    assign w_cy    = w_sum_y[CW:1];
    assign w_cz    = w_sum_z[CW:1];

    assign w_sq_x = r_dx * r_dx;
    assign w_sq_y = r_dy * r_dy;
    assign w_sq_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_flags <= '0;
            r_b_flags <= '0;
            r_c_flags <= '0;
        end else begin
            r_a_flags <= '{valid: i_tag.valid, last: i_tag.last,
                           present: i_word[6*CW], contain: w_contain};
            r_b_flags <= r_a_flags;
            r_c_flags <= r_b_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        r_dx    <= {i_px[CW-1], i_px} - {w_cx[CW-1], w_cx};
        r_dy    <= {i_py[CW-1], i_py} - {w_cy[CW-1], w_cy};
        r_dz    <= {i_pz[CW-1], i_pz} - {w_cz[CW-1], w_cz};

        r_b_idx <= r_a_idx;
        r_sq_x  <= w_sq_x;
        r_sq_y  <= w_sq_y;
        r_sq_z  <= w_sq_z;

        r_c_idx <= r_b_idx;
        r_dist  <= {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};
    end

    assign o_flags = r_c_flags;
    assign o_idx   = r_c_idx;
    assign o_dist  = r_dist;

endmodule

/* design/point_box_locate_nearest.sv */
// top level of the point-box locator: control, box table, best-match tracking
//
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata: entries and point, tuser: command
// m_axis    out  tvalid/tready             tdata: sector_index, tuser: status
// apb       in   psel/penable/pwrite       sector_count at byte address 0
//
// a write word goes straight into the table and leaves the block idle; a query scans
// sector_count entries, one entry per cycle from the table memory read port, then
// drains the pipeline; a query with zero or too large a count answers status none
// and index zero; after reset a clearing pass over all MAX_SECTORS entries marks
// every entry absent, and no word is accepted during it
// a finished result waits in the output register; a write word may still be taken
module point_box_locate_nearest #(
    parameter int MAX_SECTORS = 64,
    parameter int COORD_WIDTH = 24,
    localparam int TDATA_W = ((7 + 9 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // entry_index, entry_present, min_x, min_y, min_z, max_x, max_y, max_z,
    // point_x, point_y, point_z, zero pad
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // command
    input  logic [0:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // sector_index, zero pad
    output logic [7:0]         m_axis_tdata,
    // status
    output logic [1:0]         m_axis_tuser,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pbl_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int WORD_W = 6 * CW + 1;
    localparam int DW     = 2 * CW + 4;
    localparam int OFS_BOX = 7;
    localparam int OFS_PX  = 7 + 6 * CW;
    localparam int OFS_PY  = 7 + 7 * CW;
    localparam int OFS_PZ  = 7 + 8 * CW;

    t_state r_state, n_state;

    // configuration
    logic [6:0] r_sector_count;
    logic       w_cfg_wr;

    // scan address, also the clearing pointer
    logic [AW-1:0] r_addr;

    // table ram ports
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic [WORD_W-1:0] w_ram_rdata;

    // read tag aligned with the registered ram output
    t_scan_tag     r_rd_tag;
    logic [AW-1:0] r_rd_idx;

    // query point
    logic signed [CW-1:0] r_px, r_py, r_pz;

    // evaluation output
    t_eval_flags   w_ev_flags;
    logic [AW-1:0] w_ev_idx;
    logic [DW-1:0] w_ev_dist;

    // best-match tracking
    logic          r_found, n_found;
    logic [AW-1:0] r_found_idx, n_found_idx;
    logic          r_have, n_have;
    logic [DW-1:0] r_best, n_best;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic          w_take_contain, w_take_near;

    // pending result and output register
    logic [1:0] r_res_status;
    logic [5:0] r_res_idx;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [5:0] r_out_idx;

    // control
    logic w_in_acc, w_is_query, w_count_ok, w_wr_idx_ok;
    logic w_scan_last, w_clear_last, w_issue, w_start_query, w_load_out;
    logic w_finish;

    logic [AW+5:0] w_wr_wide;
    logic [AW+5:0] w_res_wide;
    logic [AW-1:0] w_res_idx;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_SECTOR_COUNT) ? {25'b0, r_sector_count} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= 7'd0;
        end else if (w_cfg_wr && (paddr[2] == REG_SECTOR_COUNT)) begin
            r_sector_count <= pwdata[6:0];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_is_query    = (s_axis_tuser[0] == CMD_QUERY);

    // counts above the table size behave like zero
    assign w_count_ok  = (r_sector_count != 7'd0) &&
                         (32'(r_sector_count) <= MAX_SECTORS);
    assign w_wr_idx_ok = (32'(s_axis_tdata[5:0]) < MAX_SECTORS);
    assign w_wr_wide   = {{AW{1'b0}}, s_axis_tdata[5:0]};

    assign w_scan_last  = ((32'(r_addr) + 32'd1) == 32'(r_sector_count));
    assign w_clear_last = (r_addr == AW'(MAX_SECTORS - 1));
    assign w_finish     = w_ev_flags.valid && w_ev_flags.last;

    always_comb begin
        n_state       = r_state;
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_addr;
        w_ram_wdata   = '0;
        w_issue       = 1'b0;
        w_start_query = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // present bit low, bounds left as zero
                w_ram_we = 1'b1;
                if (w_clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_is_query) begin
                        // an absent write only needs the present bit low
                        w_ram_we    = w_wr_idx_ok;
                        w_ram_waddr = w_wr_wide[AW-1:0];
                        w_ram_wdata = {s_axis_tdata[6], s_axis_tdata[OFS_BOX +: 6 * CW]};
                    end else begin
                        w_start_query = 1'b1;
                        n_state       = w_count_ok ? S_SCAN : S_DONE;
                    end
                end
            end
            S_SCAN: begin
                w_issue = 1'b1;
                if (w_scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (w_start_query) begin
                r_addr <= '0;
            end else if ((r_state == S_CLEAR) || w_issue) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    pbl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SECTORS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= '{valid: w_issue, last: w_issue && w_scan_last};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_start_query) begin
            r_px <= s_axis_tdata[OFS_PX +: CW];
            r_py <= s_axis_tdata[OFS_PY +: CW];
            r_pz <= s_axis_tdata[OFS_PZ +: CW];
        end
    end

    pbl_eval #(
        .CW (CW),
        .AW (AW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_idx   (r_rd_idx),
        .i_word  (w_ram_rdata),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .o_flags (w_ev_flags),
        .o_idx   (w_ev_idx),
        .o_dist  (w_ev_dist)
    );

    // first containing box wins; otherwise strict less keeps the first minimum
    assign w_take_contain = w_ev_flags.valid && w_ev_flags.present &&
                            w_ev_flags.contain && !r_found;
    assign w_take_near    = w_ev_flags.valid && w_ev_flags.present &&
                            (!r_have || (w_ev_dist < r_best));

    always_comb begin
        n_found     = r_found || w_take_contain;
        n_found_idx = w_take_contain ? w_ev_idx : r_found_idx;
        n_have      = r_have || w_take_near;
        n_best      = w_take_near ? w_ev_dist : r_best;
        n_best_idx  = w_take_near ? w_ev_idx : r_best_idx;
    end

    // no present entry leaves best index at zero
    assign w_res_idx  = n_found ? n_found_idx : n_best_idx;
    assign w_res_wide = {6'b0, w_res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_have  <= 1'b0;
        end else if (w_start_query) begin
            r_found <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_found <= n_found;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_query) begin
            r_best_idx   <= '0;
            r_res_status <= ST_NONE;
            r_res_idx    <= 6'd0;
        end else begin
            r_found_idx <= n_found_idx;
            r_best      <= n_best;
            r_best_idx  <= n_best_idx;
            if (w_finish) begin
                r_res_status <= n_found ? ST_INSIDE : ST_NEAREST;
                r_res_idx    <= w_res_wide[5:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_idx};
    assign m_axis_tuser  = r_out_status;

endmodule

/* design/pbl_checker.sv */
// port-level assertions of the point-box locator and their binding
module pbl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic [0:0] i_s_tuser,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata,
    input logic [1:0] i_m_tuser
);
    import pbl_pkg::*;

    // a held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) &&
                                         $stable(i_m_tuser)))
        else $error("result word changed while stalled");

    // only the three defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((i_m_tuser == ST_INSIDE) || (i_m_tuser == ST_NEAREST) ||
                        (i_m_tuser == ST_NONE)))
        else $error("undefined status code");

    // no-sector answers carry index zero
    a_none_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (i_m_tuser == ST_NONE)) |-> (i_m_tdata == 8'd0))
        else $error("no-sector answer with nonzero index");

    // a query occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && (i_s_tuser[0] == CMD_QUERY)) |=> !i_s_tready)
        else $error("word accepted right after a query");

    // pad bits above the index stay low
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[7:6] == 2'b00))
        else $error("result pad bits set");

endmodule

bind point_box_locate_nearest pbl_checker u_pbl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
